// File: rtl/core/lfs_pkg.sv
// Package with shared types and constants for the link failover selector.
package lfs_pkg;

  // Link codes; the three-bit form adds the "none selected" code.
  localparam logic [2:0] LINK_WIFI  = 3'd0;
  localparam logic [2:0] LINK_RADIO = 3'd1;
  localparam logic [2:0] LINK_CELL  = 3'd2;
  localparam logic [2:0] LINK_SAT   = 3'd3;
  localparam logic [2:0] LINK_NONE  = 3'd4;

  // Input modes.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_RADIO = 3'd1;
  localparam logic [2:0] MODE_SMS   = 3'd2;
  localparam logic [2:0] MODE_SAT   = 3'd3;
  localparam logic [2:0] MODE_WIFI  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_NOTICE = 2'd0;
  localparam logic [1:0] KIND_HB     = 2'd1;
  localparam logic [1:0] KIND_REPLAY = 2'd2;
  localparam logic [1:0] KIND_SMS_HB = 2'd3;

  // SMS target code for the last sender.
  localparam logic [1:0] TARGET_SENDER = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_NUMBERS  = 3'd1;
  localparam logic [2:0] REG_WIFI_TO  = 3'd2;
  localparam logic [2:0] REG_RADIO_TO = 3'd3;
  localparam logic [2:0] REG_SMS_TO   = 3'd4;
  localparam logic [2:0] REG_HB_PER   = 3'd5;
  localparam logic [2:0] REG_ALIVE    = 3'd6;
  localparam logic [2:0] REG_EVAL     = 3'd7;

  // Register reset values.
  localparam logic [31:0] RST_WIFI_TO  = 32'd1000;
  localparam logic [31:0] RST_RADIO_TO = 32'd4000;
  localparam logic [31:0] RST_SMS_TO   = 32'd30000;
  localparam logic [31:0] RST_HB_PER   = 32'd2000;
  localparam logic [31:0] RST_ALIVE    = 32'd30000;
  localparam logic [15:0] RST_EVAL     = 16'd100;

  // Depth of the queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Configuration register set.
  typedef struct packed {
    logic [3:0]  enable_mask;
    logic [2:0]  number_mask;
    logic [31:0] wifi_to;
    logic [31:0] radio_to;
    logic [31:0] sms_to;
    logic [31:0] hb_period;
    logic [31:0] alive_period;
    logic [15:0] eval_interval;
  } lfs_cfg_t;

  // Side effect of a write to the number mask register.
  typedef struct packed {
    logic wr;
    logic bit0;
  } lfs_cfg_wr_t;

  // Results caused by one tick; emission order runs from notice up to keep.
  typedef struct packed {
    logic       keep;
    logic [2:0] rehook;
    logic       replay;
    logic       hb;
    logic       notice;
    logic [1:0] link;
  } lfs_bundle_t;

endpackage

// File: rtl/core/link_failover_selector.sv
// Top level: register file, front part, bundle queue and back part.
// Throughput: one input transaction per cycle while the bundle queue has room.
// Results leave one per cycle while the receiver pops; a tick causes at most six, set by the front part.
// The first result of a tick passes through the bundle queue, the bundle
// load into the back part and then the output register.
// Reset is synchronous and active low and needs no sweep.
module link_failover_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_now_ms,
  input  logic        in_sender_valid,
  input  logic        in_high_lat_flag,
  input  logic        push,
  output logic        full,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_link,
  output logic [1:0]  out_sms_target,
  output logic        out_last,
  output logic        empty,
  input  logic        pop,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfs_pkg::*;

  lfs_cfg_t    cfg_r, cfg_nxt;
  lfs_cfg_wr_t cfg_wr;
  lfs_bundle_t q_din, q_dout;
  logic        wr_en, q_push, q_pop, q_full, q_empty;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:   cfg_nxt.enable_mask   = pwdata[3:0];
        REG_NUMBERS:  cfg_nxt.number_mask   = pwdata[2:0];
        REG_WIFI_TO:  cfg_nxt.wifi_to       = pwdata;
        REG_RADIO_TO: cfg_nxt.radio_to      = pwdata;
        REG_SMS_TO:   cfg_nxt.sms_to        = pwdata;
        REG_HB_PER:   cfg_nxt.hb_period     = pwdata;
        REG_ALIVE:    cfg_nxt.alive_period  = pwdata;
        default:      cfg_nxt.eval_interval = pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask   <= '0;
      cfg_r.number_mask   <= '0;
      cfg_r.wifi_to       <= RST_WIFI_TO;
      cfg_r.radio_to      <= RST_RADIO_TO;
      cfg_r.sms_to        <= RST_SMS_TO;
      cfg_r.hb_period     <= RST_HB_PER;
      cfg_r.alive_period  <= RST_ALIVE;
      cfg_r.eval_interval <= RST_EVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A number mask write also reloads the sender flag.
  assign cfg_wr.wr   = wr_en && (reg_idx == REG_NUMBERS);
  assign cfg_wr.bit0 = pwdata[0];

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_ENABLE:   prdata = {28'd0, cfg_r.enable_mask};
      REG_NUMBERS:  prdata = {29'd0, cfg_r.number_mask};
      REG_WIFI_TO:  prdata = cfg_r.wifi_to;
      REG_RADIO_TO: prdata = cfg_r.radio_to;
      REG_SMS_TO:   prdata = cfg_r.sms_to;
      REG_HB_PER:   prdata = cfg_r.hb_period;
      REG_ALIVE:    prdata = cfg_r.alive_period;
      default:      prdata = {16'd0, cfg_r.eval_interval};
    endcase
  end

  assign full = q_full;

  lfs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_now_ms        (in_now_ms),
    .in_sender_valid  (in_sender_valid),
    .in_high_lat_flag (in_high_lat_flag),
    .push             (push),
    .cfg              (cfg_r),
    .cfg_wr           (cfg_wr),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_din)
  );

  lfs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  lfs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_dout),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_kind       (out_kind),
    .out_link       (out_link),
    .out_sms_target (out_sms_target),
    .out_last       (out_last),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

// File: rtl/core/lfs_queue.sv
// Short queue of result bundles between the front and back parts.
module lfs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lfs_pkg::lfs_bundle_t din,
  input  logic                pop,
  output lfs_pkg::lfs_bundle_t dout,
  output logic                full,
  output logic                empty
);
  import lfs_pkg::*;

  lfs_bundle_t        mem [QDepth];
  logic [QAw-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]       count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == (QAw+1)'(QDepth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAw'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAw'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/core/lfs_front.sv
// Front part: accepts events, keeps link state and classifies tick results.
module lfs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_mode,
  input  logic [31:0]          in_now_ms,
  input  logic                 in_sender_valid,
  input  logic                 in_high_lat_flag,
  input  logic                 push,
  input  lfs_pkg::lfs_cfg_t    cfg,
  input  lfs_pkg::lfs_cfg_wr_t cfg_wr,
  input  logic                 q_full,
  output logic                 q_push,
  output lfs_pkg::lfs_bundle_t q_data
);
  import lfs_pkg::*;

  logic [2:0]  active_r, active_nxt;
  logic [2:0]  announced_r, announced_nxt;
  logic [31:0] wifi_t_r, wifi_t_nxt;
  logic [31:0] radio_t_r, radio_t_nxt;
  logic [31:0] sms_t_r, sms_t_nxt;
  logic [31:0] eval_t_r, eval_t_nxt;
  logic [31:0] hb_mark_r, hb_mark_nxt;
  logic [31:0] alive_mark_r, alive_mark_nxt;
  logic        rehook_done_r, rehook_done_nxt;
  logic        replay_r, replay_nxt;
  logic        sender_ok_r, sender_ok_nxt;

  logic        accept;
  logic [31:0] d_wifi, d_radio, d_sms, d_eval, d_hb, d_alive;
  logic        wifi_fresh, wifi_lost, radio_fresh, radio_lost, sms_fresh, sms_lost;
  logic        eval_go, hb_due, alive_due;
  logic        sel_do;
  logic [2:0]  sel_link;
  logic [2:0]  act;
  logic        replay_e, rehook_e, enter_cell;
  logic        fire_rehook, fire_keep;
  lfs_bundle_t bundle;

  assign accept = push && !q_full;

  // Elapsed times since each mark, modulo 2^32.
  assign d_wifi  = in_now_ms - wifi_t_r;
  assign d_radio = in_now_ms - radio_t_r;
  assign d_sms   = in_now_ms - sms_t_r;
  assign d_eval  = in_now_ms - eval_t_r;
  assign d_hb    = in_now_ms - hb_mark_r;
  assign d_alive = in_now_ms - alive_mark_r;

  assign wifi_fresh  = d_wifi < cfg.wifi_to;
  assign wifi_lost   = d_wifi > cfg.wifi_to;
  assign radio_fresh = d_radio < cfg.radio_to;
  assign radio_lost  = d_radio > cfg.radio_to;
  assign sms_fresh   = d_sms < cfg.sms_to;
  assign sms_lost    = d_sms > cfg.sms_to;
  assign eval_go     = d_eval >= {16'd0, cfg.eval_interval};
  assign hb_due      = d_hb >= cfg.hb_period;
  assign alive_due   = d_alive >= cfg.alive_period;

  // Link evaluation: pick the link to switch to, if any is enabled.
  always_comb begin
    sel_do   = 1'b0;
    sel_link = active_r;
    case (active_r)
      LINK_WIFI: begin
        if (wifi_lost) begin
          if (cfg.enable_mask[1]) begin
            sel_do = 1'b1; sel_link = LINK_RADIO;
          end else if (cfg.enable_mask[2]) begin
            sel_do = 1'b1; sel_link = LINK_CELL;
          end else if (cfg.enable_mask[3]) begin
            sel_do = 1'b1; sel_link = LINK_SAT;
          end else if (cfg.enable_mask[0]) begin
            sel_do = 1'b1; sel_link = LINK_WIFI;
          end
        end
      end
      LINK_RADIO: begin
        if (wifi_fresh) begin
          sel_do = cfg.enable_mask[0]; sel_link = LINK_WIFI;
        end else if (radio_lost) begin
          if (cfg.enable_mask[2]) begin
            sel_do = 1'b1; sel_link = LINK_CELL;
          end else if (cfg.enable_mask[3]) begin
            sel_do = 1'b1; sel_link = LINK_SAT;
          end else if (cfg.enable_mask[1]) begin
            sel_do = 1'b1; sel_link = LINK_RADIO;
          end
        end
      end
      LINK_CELL: begin
        if (wifi_fresh) begin
          sel_do = cfg.enable_mask[0]; sel_link = LINK_WIFI;
        end else if (radio_fresh) begin
          sel_do = cfg.enable_mask[1]; sel_link = LINK_RADIO;
        end else if (sms_lost) begin
          if (cfg.enable_mask[3]) begin
            sel_do = 1'b1; sel_link = LINK_SAT;
          end else if (cfg.enable_mask[1]) begin
            sel_do = 1'b1; sel_link = LINK_RADIO;
          end
        end
      end
      LINK_SAT: begin
        if (wifi_fresh) begin
          sel_do = cfg.enable_mask[0]; sel_link = LINK_WIFI;
        end else if (radio_fresh) begin
          sel_do = cfg.enable_mask[1]; sel_link = LINK_RADIO;
        end else if (sms_fresh) begin
          sel_do = cfg.enable_mask[2]; sel_link = LINK_CELL;
        end
      end
      default: begin
        sel_do = cfg.enable_mask[0]; sel_link = LINK_WIFI;
      end
    endcase
    sel_do = sel_do && eval_go;
  end

  // State as seen after the evaluation step.
  assign act        = sel_do ? sel_link : active_r;
  assign enter_cell = sel_do && (sel_link == LINK_CELL);
  assign replay_e   = (sel_do && (sel_link == LINK_WIFI || sel_link == LINK_RADIO))
                      ? 1'b0 : replay_r;
  assign rehook_e   = (sel_do && (sel_link == LINK_SAT)) ? 1'b0 : rehook_done_r;

  // Periodic work after evaluation.
  assign fire_rehook = cfg.enable_mask[3] && (act == LINK_SAT) && !rehook_e;
  assign fire_keep   = cfg.enable_mask[2] && (act == LINK_CELL) &&
                       (enter_cell ? (cfg.alive_period == 32'd0) : alive_due);

  always_comb begin
    bundle.notice = sel_do && (announced_r != sel_link);
    bundle.link   = sel_link[1:0];
    bundle.hb     = hb_due && (act != LINK_RADIO) && (act != LINK_WIFI);
    bundle.replay = bundle.hb && replay_e;
    bundle.rehook = fire_rehook ? cfg.number_mask : 3'b000;
    bundle.keep   = fire_keep && sender_ok_r;
  end

  assign q_data = bundle;
  assign q_push = accept && (in_mode == MODE_TICK) &&
                  (bundle.notice || bundle.hb || bundle.replay ||
                   (bundle.rehook != 3'b000) || bundle.keep);

  // Next state for frames and ticks.
  always_comb begin
    active_nxt      = active_r;
    announced_nxt   = announced_r;
    wifi_t_nxt      = wifi_t_r;
    radio_t_nxt     = radio_t_r;
    sms_t_nxt       = sms_t_r;
    eval_t_nxt      = eval_t_r;
    hb_mark_nxt     = hb_mark_r;
    alive_mark_nxt  = alive_mark_r;
    rehook_done_nxt = rehook_done_r;
    replay_nxt      = replay_r;
    sender_ok_nxt   = sender_ok_r;
    if (cfg_wr.wr) begin
      sender_ok_nxt = cfg_wr.bit0;
    end
    if (accept) begin
      case (in_mode)
        MODE_TICK: begin
          if (eval_go) begin
            eval_t_nxt = in_now_ms;
          end
          if (sel_do) begin
            active_nxt    = sel_link;
            announced_nxt = sel_link;
          end
          if (enter_cell) begin
            sms_t_nxt      = in_now_ms;
            alive_mark_nxt = in_now_ms;
          end
          replay_nxt      = replay_e;
          rehook_done_nxt = rehook_e || fire_rehook;
          if (bundle.hb) begin
            hb_mark_nxt = in_now_ms;
          end
          if (fire_keep) begin
            alive_mark_nxt = in_now_ms;
          end
        end
        MODE_RADIO: begin
          radio_t_nxt = in_now_ms;
        end
        MODE_SMS: begin
          sender_ok_nxt = in_sender_valid;
          sms_t_nxt     = in_now_ms;
          if (in_high_lat_flag) begin
            replay_nxt = 1'b1;
          end
        end
        MODE_SAT: begin
          if (active_r == LINK_SAT) begin
            replay_nxt = 1'b1;
          end
        end
        MODE_WIFI: begin
          wifi_t_nxt = in_now_ms;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= LINK_NONE;
      announced_r   <= LINK_NONE;
      wifi_t_r      <= '0;
      radio_t_r     <= '0;
      sms_t_r       <= '0;
      eval_t_r      <= '0;
      hb_mark_r     <= '0;
      alive_mark_r  <= '0;
      rehook_done_r <= 1'b0;
      replay_r      <= 1'b0;
      sender_ok_r   <= 1'b0;
    end else begin
      active_r      <= active_nxt;
      announced_r   <= announced_nxt;
      wifi_t_r      <= wifi_t_nxt;
      radio_t_r     <= radio_t_nxt;
      sms_t_r       <= sms_t_nxt;
      eval_t_r      <= eval_t_nxt;
      hb_mark_r     <= hb_mark_nxt;
      alive_mark_r  <= alive_mark_nxt;
      rehook_done_r <= rehook_done_nxt;
      replay_r      <= replay_nxt;
      sender_ok_r   <= sender_ok_nxt;
    end
  end

endmodule

// File: rtl/core/lfs_back.sv
// Back part: turns queued bundles into one result per cycle while the receiver pops.
module lfs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lfs_pkg::lfs_bundle_t q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_link,
  output logic [1:0]           out_sms_target,
  output logic                 out_last,
  output logic                 empty,
  input  logic                 pop
);
  import lfs_pkg::*;

  // Pending results, bit 0 first: notice, hb, replay, rehook 0..2, keepalive.
  logic [6:0] pend_r, pend_nxt;
  logic [1:0] link_r, link_nxt;
  logic       cur_v_r, cur_v_nxt;
  logic       out_v_r, out_v_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] olink_r, olink_nxt;
  logic [1:0] target_r, target_nxt;
  logic       last_r, last_nxt;

  logic       slot_free, emit, load;
  logic [2:0] pick;
  logic [6:0] rest;

  assign slot_free = !out_v_r || pop;
  assign emit      = cur_v_r && slot_free;

  // Lowest pending result goes next.
  always_comb begin
    pick = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick = 3'(i);
      end
    end
    rest       = pend_r;
    rest[pick] = 1'b0;
  end

  assign load  = !cur_v_r || (emit && (rest == 7'd0));
  assign q_pop = load && !q_empty;

  // Current bundle bookkeeping.
  always_comb begin
    pend_nxt  = pend_r;
    link_nxt  = link_r;
    cur_v_nxt = cur_v_r;
    if (emit) begin
      pend_nxt  = rest;
      cur_v_nxt = (rest != 7'd0);
    end
    if (q_pop) begin
      pend_nxt  = {q_data.keep, q_data.rehook, q_data.replay, q_data.hb, q_data.notice};
      link_nxt  = q_data.link;
      cur_v_nxt = 1'b1;
    end
  end

  // Output register.
  always_comb begin
    out_v_nxt  = out_v_r && !pop;
    kind_nxt   = kind_r;
    olink_nxt  = olink_r;
    target_nxt = target_r;
    last_nxt   = last_r;
    if (emit) begin
      out_v_nxt  = 1'b1;
      olink_nxt  = 2'd0;
      target_nxt = 2'd0;
      last_nxt   = (rest == 7'd0);
      case (pick)
        3'd0: begin
          kind_nxt  = KIND_NOTICE;
          olink_nxt = link_r;
        end
        3'd1: kind_nxt = KIND_HB;
        3'd2: kind_nxt = KIND_REPLAY;
        3'd3, 3'd4, 3'd5: begin
          kind_nxt   = KIND_SMS_HB;
          target_nxt = 2'(pick - 3'd3);
        end
        default: begin
          kind_nxt   = KIND_SMS_HB;
          target_nxt = TARGET_SENDER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    link_r   <= link_nxt;
    kind_r   <= kind_nxt;
    olink_r  <= olink_nxt;
    target_r <= target_nxt;
    last_r   <= last_nxt;
  end

  assign empty          = !out_v_r;
  assign out_kind       = kind_r;
  assign out_link       = olink_r;
  assign out_sms_target = target_r;
  assign out_last       = last_r;

endmodule

// File: rtl/core/lfs_checker.sv
// Port-level checker for the link failover selector, with its bind.
module lfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       pready,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  // Reset leaves no result waiting.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // Reset drains the bundle queue.
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("queue full after reset");

  // A stalled result keeps its kind.
  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind)))
    else $error("stalled result changed kind");

  // A stalled result keeps its end marker.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> $stable(out_last))
    else $error("stalled result changed last flag");

endmodule

bind link_failover_selector lfs_checker u_lfs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .pready   (pready),
  .out_kind (out_kind),
  .out_last (out_last)
);

// File: tb/link_failover_selector_tb.sv
// Self-checking testbench for the link failover selector: directed and random event traffic.
`timescale 1ns / 1ps

module link_failover_selector_tb;
  import lfs_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int MAX_PRINTED = 40;

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] link;
    logic [1:0] target;
    logic       last;
  } link_msg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [2:0]  in_mode = MODE_TICK;
  logic [31:0] in_now_ms = 32'd0;
  logic        in_sender_valid = 1'b0;
  logic        in_high_lat_flag = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  out_kind;
  logic [1:0]  out_link;
  logic [1:0]  out_sms_target;
  logic        out_last;
  logic        empty;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the register file and of the selector state.
  lfs_cfg_t    cfg_m;
  logic [2:0]  cur_link = LINK_NONE;
  logic [2:0]  told_link = LINK_NONE;
  logic [31:0] t_wifi = 32'd0;
  logic [31:0] t_radio = 32'd0;
  logic [31:0] t_sms = 32'd0;
  logic [31:0] t_eval = 32'd0;
  logic [31:0] hb_mark = 32'd0;
  logic [31:0] alive_mark = 32'd0;
  bit          rehook_sent = 1'b0;
  bit          replay_pend = 1'b0;
  bit          reply_ok = 1'b0;

  link_msg_t   step_msgs[$];
  link_msg_t   msg_due[$];

  int          err_count = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 29;
  int          recv_idle_pct = 48;
  logic [31:0] clock_ms = 32'd0;

  link_failover_selector u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_now_ms        (in_now_ms),
    .in_sender_valid  (in_sender_valid),
    .in_high_lat_flag (in_high_lat_flag),
    .push             (push),
    .full             (full),
    .out_kind         (out_kind),
    .out_link         (out_link),
    .out_sms_target   (out_sms_target),
    .out_last         (out_last),
    .empty            (empty),
    .pop              (pop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Selector prediction.
  // ---------------------------------------------------------------------------

  function automatic bit link_on(input logic [2:0] l);
    return cfg_m.enable_mask[l[1:0]];
  endfunction

  function automatic void note(input logic [1:0] kind, input logic [1:0] lk,
                               input logic [1:0] tgt);
    link_msg_t m;
    m.kind   = kind;
    m.link   = lk;
    m.target = tgt;
    m.last   = 1'b0;
    if (step_msgs.size() < 6) step_msgs.push_back(m);
  endfunction

  // Makes a link active if it is enabled; announces it when it is new.
  function automatic bit switch_to(input logic [2:0] l, input logic [31:0] now);
    if (!link_on(l)) return 1'b0;
    cur_link = l;
    if (l == LINK_SAT) rehook_sent = 1'b0;
    if (l == LINK_CELL) begin
      t_sms      = now;
      alive_mark = now;
    end
    if (l == LINK_WIFI || l == LINK_RADIO) replay_pend = 1'b0;
    if (told_link != l) begin
      told_link = l;
      note(KIND_NOTICE, l[1:0], 2'd0);
    end
    return 1'b1;
  endfunction

  // Rate-limited link evaluation; silences are taken before any switch.
  function automatic void pick_link(input logic [31:0] now);
    logic [31:0] since_wifi;
    logic [31:0] since_radio;
    logic [31:0] since_sms;
    logic [31:0] since_eval;
    since_wifi  = now - t_wifi;
    since_radio = now - t_radio;
    since_sms   = now - t_sms;
    since_eval  = now - t_eval;
    if (since_eval < {16'd0, cfg_m.eval_interval}) return;
    t_eval = now;
    case (cur_link)
      LINK_WIFI: begin
        if (since_wifi > cfg_m.wifi_to) begin
          if (!switch_to(LINK_RADIO, now))
            if (!switch_to(LINK_CELL, now))
              if (!switch_to(LINK_SAT, now)) void'(switch_to(LINK_WIFI, now));
        end
      end
      LINK_RADIO: begin
        if (since_wifi < cfg_m.wifi_to) void'(switch_to(LINK_WIFI, now));
        else if (since_radio > cfg_m.radio_to) begin
          if (!switch_to(LINK_CELL, now))
            if (!switch_to(LINK_SAT, now)) void'(switch_to(LINK_RADIO, now));
        end
      end
      LINK_CELL: begin
        if (since_wifi < cfg_m.wifi_to) void'(switch_to(LINK_WIFI, now));
        else if (since_radio < cfg_m.radio_to) void'(switch_to(LINK_RADIO, now));
        else if (since_sms > cfg_m.sms_to) begin
          if (!switch_to(LINK_SAT, now)) void'(switch_to(LINK_RADIO, now));
        end
      end
      LINK_SAT: begin
        if (since_wifi < cfg_m.wifi_to) void'(switch_to(LINK_WIFI, now));
        else if (since_radio < cfg_m.radio_to) void'(switch_to(LINK_RADIO, now));
        else if (since_sms < cfg_m.sms_to) void'(switch_to(LINK_CELL, now));
      end
      default: void'(switch_to(LINK_WIFI, now));
    endcase
  endfunction

  // Applies one accepted input transaction and queues the results it causes.
  function automatic void predict_item(input logic [2:0] mode, input logic [31:0] now,
                                       input bit snd, input bit hl);
    link_msg_t m;
    step_msgs.delete();
    case (mode)
      MODE_RADIO: t_radio = now;
      MODE_WIFI:  t_wifi = now;
      MODE_SAT:   if (cur_link == LINK_SAT) replay_pend = 1'b1;
      MODE_SMS: begin
        reply_ok = snd;
        if (hl) replay_pend = 1'b1;
        t_sms = now;
      end
      MODE_TICK: begin
        pick_link(now);
        // Ground heartbeat whenever no terrestrial link carries traffic.
        if (now - hb_mark >= cfg_m.hb_period && cur_link != LINK_RADIO &&
            cur_link != LINK_WIFI) begin
          hb_mark = now;
          note(KIND_HB, 2'd0, 2'd0);
          if (replay_pend) note(KIND_REPLAY, 2'd0, 2'd0);
        end
        // One-time rehook to every valid number after entering satellite.
        if (link_on(LINK_SAT) && cur_link == LINK_SAT && !rehook_sent) begin
          for (int i = 0; i < 3; i++) begin
            if (cfg_m.number_mask[i]) note(KIND_SMS_HB, 2'd0, i[1:0]);
          end
          rehook_sent = 1'b1;
        end
        // Keepalive to the last sender while on cellular.
        if (link_on(LINK_CELL) && cur_link == LINK_CELL &&
            now - alive_mark >= cfg_m.alive_period) begin
          alive_mark = now;
          if (reply_ok) note(KIND_SMS_HB, 2'd0, TARGET_SENDER);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < step_msgs.size(); i++) begin
      m = step_msgs[i];
      m.last = (i == step_msgs.size() - 1);
      msg_due.push_back(m);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Sends one input transaction, with random idle cycles ahead of it.
  task automatic push_item(input logic [2:0] mode, input logic [31:0] now,
                           input bit snd, input bit hl);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_mode          <= mode;
    in_now_ms        <= now;
    in_sender_valid  <= snd;
    in_high_lat_flag <= hl;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(mode, now, snd, hl);
  endtask

  // Stops sending, waits for every expected result, then holds off a while.
  task automatic wait_idle(input int hold_cycles);
    push <= 1'b0;
    @(posedge clk);
    while (msg_due.size() != 0) @(posedge clk);
    repeat (hold_cycles) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then an idle gap.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:   cfg_m.enable_mask = val[3:0];
      REG_NUMBERS: begin
        cfg_m.number_mask = val[2:0];
        reply_ok          = val[0];
      end
      REG_WIFI_TO:  cfg_m.wifi_to = val;
      REG_RADIO_TO: cfg_m.radio_to = val;
      REG_SMS_TO:   cfg_m.sms_to = val;
      REG_HB_PER:   cfg_m.hb_period = val;
      REG_ALIVE:    cfg_m.alive_period = val;
      REG_EVAL:     cfg_m.eval_interval = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Writes the whole register set; unused upper bits carry random junk.
  task automatic apply_settings(input logic [3:0] en, input logic [2:0] nums,
                                input logic [31:0] wifi_to, input logic [31:0] radio_to,
                                input logic [31:0] sms_to, input logic [31:0] hb_per,
                                input logic [31:0] alive_per, input logic [15:0] eval_iv);
    wait_idle(10);
    write_reg(REG_ENABLE, ($urandom & 32'hFFFF_FFF0) | {28'd0, en});
    write_reg(REG_NUMBERS, ($urandom & 32'hFFFF_FFF8) | {29'd0, nums});
    write_reg(REG_WIFI_TO, wifi_to);
    write_reg(REG_RADIO_TO, radio_to);
    write_reg(REG_SMS_TO, sms_to);
    write_reg(REG_HB_PER, hb_per);
    write_reg(REG_ALIVE, alive_per);
    write_reg(REG_EVAL, ($urandom & 32'hFFFF_0000) | {16'd0, eval_iv});
  endtask

  // Random event traffic. Frames come only from the links that are "up" in
  // the current stretch, so links really go silent and come back.
  task automatic random_traffic(input int count, input bit hold_once);
    int          sent;
    int          pick;
    bit          held;
    logic [3:0]  up_links;
    logic [2:0]  mode;
    logic [31:0] step_ms;
    sent     = 0;
    held     = 1'b0;
    up_links = 4'hF;
    while (sent < count) begin
      if ($urandom_range(39) == 0) up_links = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 45) mode = MODE_TICK;
      else if (pick < 58) mode = up_links[0] ? MODE_WIFI : MODE_TICK;
      else if (pick < 71) mode = up_links[1] ? MODE_RADIO : MODE_TICK;
      else if (pick < 84) mode = up_links[2] ? MODE_SMS : MODE_TICK;
      else if (pick < 95) mode = up_links[3] ? MODE_SAT : MODE_TICK;
      else mode = 3'($urandom_range(7, 5));
      pick = $urandom_range(99);
      if (pick < 70) step_ms = $urandom_range(300);
      else if (pick < 96) step_ms = $urandom_range(3000);
      else step_ms = $urandom;
      clock_ms = clock_ms + step_ms;
      if (hold_once && !held && sent == count / 2) begin
        wait_idle(0);
        held = 1'b1;
      end
      push_item(mode, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (mode <= MODE_WIFI) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: no link enabled, heartbeats with no active link, replay.
  task automatic test_reset_values();
    push_item(MODE_TICK, 32'd100, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd2000, 1'b0, 1'b0);
    push_item(MODE_SMS, 32'd2100, 1'b1, 1'b1);
    push_item(MODE_TICK, 32'd4100, 1'b0, 1'b0);
    push_item(MODE_SAT, 32'd4200, 1'b1, 1'b1);
  endtask

  // Walks the whole failover chain and back, with the wrap of the clock.
  task automatic test_failover_walk();
    apply_settings(4'hF, 3'h7, 32'd300, 32'd800, 32'd3000, 32'd500, 32'd1000, 16'd50);
    push_item(MODE_WIFI, 32'd10000, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd10100, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd10200, 1'b0, 1'b0);
    push_item(MODE_RADIO, 32'd10250, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd10500, 1'b0, 1'b0);
    push_item(MODE_WIFI, 32'd10550, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd10600, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd11700, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd12000, 1'b0, 1'b0);
    push_item(MODE_SMS, 32'd12100, 1'b1, 1'b1);
    push_item(MODE_TICK, 32'd13200, 1'b0, 1'b0);
    // Cellular goes silent: satellite with heartbeat, replay and full rehook.
    push_item(MODE_TICK, 32'd16500, 1'b0, 1'b0);
    push_item(MODE_SAT, 32'd16600, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd16700, 1'b0, 1'b0);
    push_item(MODE_SMS, 32'd16800, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd17000, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'd18100, 1'b0, 1'b0);
    // Unused modes are ignored.
    push_item(3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(3'd6, 32'd0, 1'b0, 1'b0);
    push_item(3'd7, 32'h5A5A_A5A5, 1'b1, 1'b0);
    push_item(MODE_RADIO, 32'hFFFF_FF00, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'h0000_0010, 1'b0, 1'b0);
    push_item(MODE_WIFI, 32'h0000_0020, 1'b0, 1'b0);
    push_item(MODE_TICK, 32'h0000_0080, 1'b0, 1'b0);
    clock_ms = 32'h0000_0080;
  endtask

  task automatic test_random_phase(input int s_idle, input int r_idle, input logic [3:0] en,
                                   input bit hold_once);
    apply_settings(en, 3'($urandom_range(7)), $urandom_range(2000, 100),
                   $urandom_range(4000, 300), $urandom_range(6000, 500),
                   $urandom_range(3000, 200), $urandom_range(5000, 200),
                   16'($urandom_range(200)));
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    random_traffic(100, hold_once);
  endtask

  // Register extremes: all zero, all ones, then zero timings with every link.
  task automatic test_register_extremes();
    apply_settings(4'h0, 3'h0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
    random_traffic(8, 1'b0);
    apply_settings(4'hF, 3'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    random_traffic(8, 1'b0);
    apply_settings(4'hF, 3'h7, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
    random_traffic(20, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    link_msg_t want;
    if (rst_n && pop && !empty) begin
      if (msg_due.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d link %0d target %0d last %0d",
                             out_kind, out_link, out_sms_target, out_last));
      end else begin
        want = msg_due.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("link", out_link, want.link);
        check_field("sms_target", out_sms_target, want.target);
        check_field("last", {1'b0, out_last}, {1'b0, want.last});
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("link_failover_selector_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_m.enable_mask   = 4'd0;
    cfg_m.number_mask   = 3'd0;
    cfg_m.wifi_to       = RST_WIFI_TO;
    cfg_m.radio_to      = RST_RADIO_TO;
    cfg_m.sms_to        = RST_SMS_TO;
    cfg_m.hb_period     = RST_HB_PER;
    cfg_m.alive_period  = RST_ALIVE;
    cfg_m.eval_interval = RST_EVAL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_failover_walk();
    test_random_phase(29, 48, 4'hF, 1'b0);
    test_random_phase(48, 29, 4'($urandom_range(15) | 1), 1'b1);
    test_random_phase(0, 0, 4'($urandom_range(15)), 1'b0);
    test_register_extremes();

    wait_idle(20);
    if (msg_due.size() != 0) flag_error("expected results left over");
    if (err_count == 0) begin
      $display("link_failover_selector_tb: PASS");
    end else begin
      $display("link_failover_selector_tb: FAIL");
    end
    $finish;
  end

endmodule
